// ----- sv/rbs_pkg.sv -----
`default_nettype none
package rbs_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int T_W        = 32;
  localparam int DIFF_W     = T_W + 1;
  localparam int Q_W        = T_W + 1;
  localparam int NUM_W      = DIFF_W + FRAC_BITS;
  localparam int STEP_BITS  = 3;
  localparam int DIV_STAGES = Q_W / STEP_BITS;
  localparam int AXES       = 3;
  localparam int LANES      = 2 * AXES;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TEST = 1'b1;

  typedef enum logic [1:0] {
    ST_LOADED = 2'd0,
    ST_MISS   = 2'd1,
    ST_ENTER  = 2'd2,
    ST_INSIDE = 2'd3
  } status_e;

  localparam logic signed [T_W-1:0] T_MAX = {1'b0, {(T_W-1){1'b1}}};
  localparam logic signed [T_W-1:0] T_MIN = {1'b1, {(T_W-1){1'b0}}};
  localparam logic [Q_W-1:0] Q_POS_LIM = {2'b00, {(T_W-1){1'b1}}};
  localparam logic [Q_W-1:0] Q_NEG_LIM = {2'b01, {(T_W-1){1'b0}}};

  typedef struct packed {
    logic [DIFF_W-1:0] nmag;
    logic              nneg;
    logic              nzero;
  } num_t;

  typedef struct packed {
    logic [T_W-1:0] dmag;
    logic           dneg;
    logic           dzero;
  } den_t;

  typedef struct packed {
    logic                          is_test;
    num_t [LANES-1:0]              num;
    den_t [AXES-1:0]               den;
    logic signed [T_W-1:0]         lo;
    logic signed [T_W-1:0]         hi;
  } item_t;

  typedef struct packed {
    logic [T_W-1:0]  r;
    logic [Q_W-1:0]  low;
    logic [Q_W-1:0]  q;
    logic [T_W-1:0]  dmag;
    logic            ovf;
    logic            neg;
    logic            dzero;
    logic            nneg;
    logic            nzero;
  } lane_t;

  typedef struct packed {
    logic                  is_test;
    logic signed [T_W-1:0] lo;
    logic signed [T_W-1:0] hi;
  } meta_t;

  function automatic lane_t lane_init(num_t n, den_t d);
    lane_t                      l;
    logic [NUM_W-1:0]           nfull;
    logic [T_W-1:0]             top;
    nfull   = {n.nmag, {FRAC_BITS{1'b0}}};
    top     = T_W'(nfull[NUM_W-1:Q_W]);
    l.ovf   = (top >= d.dmag);
    l.r     = l.ovf ? '0 : top;
    l.low   = nfull[Q_W-1:0];
    l.q     = '0;
    l.dmag  = d.dmag;
    l.neg   = n.nneg ^ d.dneg;
    l.dzero = d.dzero;
    l.nneg  = n.nneg;
    l.nzero = n.nzero;
    return l;
  endfunction

  function automatic lane_t div_step(lane_t l);
    lane_t          o;
    logic [T_W:0]   t;
    logic           bit_q;
    o = l;
    for (int i = 0; i < STEP_BITS; i++) begin
      t     = {o.r, o.low[Q_W-1]};
      o.low = {o.low[Q_W-2:0], 1'b0};
      bit_q = (t >= {1'b0, o.dmag});
      if (bit_q) begin
        t = t - {1'b0, o.dmag};
      end
      o.r = t[T_W-1:0];
      o.q = {o.q[Q_W-2:0], bit_q};
    end
    return o;
  endfunction

  function automatic logic signed [T_W-1:0] lane_result(lane_t l);
    logic [Q_W-1:0]        qn;
    logic signed [T_W-1:0] res;
    qn = -l.q;
    if (l.dzero) begin
      res = l.nzero ? '0 : (l.nneg ? T_MIN : T_MAX);
    end else if (l.neg) begin
      res = (l.ovf || l.q > Q_NEG_LIM) ? T_MIN : qn[T_W-1:0];
    end else begin
      res = (l.ovf || l.q > Q_POS_LIM) ? T_MAX : l.q[T_W-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- sv/rbs_front.sv -----
`default_nettype none
module rbs_front (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire logic                                        in_valid_i,
  output logic                                             in_stall_o,
  input  wire logic                                        req_type_i,
  input  wire logic [rbs_pkg::AXES-1:0][rbs_pkg::T_W-1:0]  vec_a_i,
  input  wire logic [rbs_pkg::AXES-1:0][rbs_pkg::T_W-1:0]  vec_b_i,
  input  wire logic signed [rbs_pkg::T_W-1:0]              interval_lo_i,
  input  wire logic signed [rbs_pkg::T_W-1:0]              interval_hi_i,
  output logic                                             push_valid_o,
  input  wire logic                                        push_full_i,
  output rbs_pkg::item_t                                   push_item_o
);

  logic [rbs_pkg::AXES-1:0][rbs_pkg::T_W-1:0] org_q, dir_q;
  logic signed [rbs_pkg::T_W-1:0]             lo_q, hi_q;
  logic                                       accept;

  assign in_stall_o   = push_full_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i && !push_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q <= '0;
      dir_q <= '0;
      lo_q  <= '0;
      hi_q  <= '0;
    end else if (accept && req_type_i == rbs_pkg::REQ_LOAD) begin
      org_q <= vec_a_i;
      dir_q <= vec_b_i;
      lo_q  <= interval_lo_i;
      hi_q  <= interval_hi_i;
    end
  end

  always_comb begin
    logic [rbs_pkg::DIFF_W-1:0] da, db;
    logic [rbs_pkg::T_W-1:0]    dv;
    push_item_o         = '0;
    push_item_o.is_test = (req_type_i == rbs_pkg::REQ_TEST);
    push_item_o.lo      = lo_q;
    push_item_o.hi      = hi_q;
    for (int i = 0; i < rbs_pkg::AXES; i++) begin
      da = {vec_a_i[i][rbs_pkg::T_W-1], vec_a_i[i]} - {org_q[i][rbs_pkg::T_W-1], org_q[i]};
      db = {vec_b_i[i][rbs_pkg::T_W-1], vec_b_i[i]} - {org_q[i][rbs_pkg::T_W-1], org_q[i]};
      push_item_o.num[2*i].nneg    = da[rbs_pkg::DIFF_W-1];
      push_item_o.num[2*i].nmag    = da[rbs_pkg::DIFF_W-1] ? -da : da;
      push_item_o.num[2*i].nzero   = (da == '0);
      push_item_o.num[2*i+1].nneg  = db[rbs_pkg::DIFF_W-1];
      push_item_o.num[2*i+1].nmag  = db[rbs_pkg::DIFF_W-1] ? -db : db;
      push_item_o.num[2*i+1].nzero = (db == '0);
      dv = dir_q[i];
      push_item_o.den[i].dneg  = dv[rbs_pkg::T_W-1];
      push_item_o.den[i].dmag  = dv[rbs_pkg::T_W-1] ? -dv : dv;
      push_item_o.den[i].dzero = (dv == '0);
    end
  end

endmodule
`default_nettype wire

// ----- sv/rbs_queue.sv -----
`default_nettype none
module rbs_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_valid_i,
  output logic                 push_full_o,
  input  wire rbs_pkg::item_t  push_item_i,
  output logic                 pop_valid_o,
  input  wire logic            pop_stall_i,
  output rbs_pkg::item_t       pop_item_o
);

  rbs_pkg::item_t mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q;
  logic           push, pop;

  assign push_full_o = (count_q == 2'd2);
  assign pop_valid_o = (count_q != 2'd0);
  assign push        = push_valid_i && !push_full_o;
  assign pop         = pop_valid_o && !pop_stall_i;
  assign pop_item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule
`default_nettype wire

// ----- sv/rbs_back.sv -----
`default_nettype none
module rbs_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        pop_valid_i,
  output logic                             pop_stall_o,
  input  wire rbs_pkg::item_t              pop_item_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [1:0]                       status_o,
  output logic signed [rbs_pkg::T_W-1:0]   t_near_o,
  output logic signed [rbs_pkg::T_W-1:0]   t_far_o
);

  localparam int NS = rbs_pkg::DIV_STAGES + 2;

  logic [NS-1:0]  v_q;
  logic [NS:0]    en;
  rbs_pkg::lane_t [rbs_pkg::LANES-1:0] lp_q [rbs_pkg::DIV_STAGES+1];
  rbs_pkg::meta_t meta_q [NS];
  logic signed [rbs_pkg::T_W-1:0] mlo_q [rbs_pkg::AXES];
  logic signed [rbs_pkg::T_W-1:0] mhi_q [rbs_pkg::AXES];
  logic                            out_v_q;
  rbs_pkg::status_e                st_q;
  logic signed [rbs_pkg::T_W-1:0]  near_q, far_q;

  always_comb begin
    en[NS] = !out_v_q || !out_stall_i;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign pop_stall_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (en[0]) v_q[0] <= pop_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
      if (en[NS]) out_v_q <= v_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < rbs_pkg::LANES; i++) begin
        lp_q[0][i] <= rbs_pkg::lane_init(pop_item_i.num[i], pop_item_i.den[i/2]);
      end
      meta_q[0] <= '{is_test: pop_item_i.is_test, lo: pop_item_i.lo, hi: pop_item_i.hi};
    end
    for (int k = 1; k <= rbs_pkg::DIV_STAGES; k++) begin
      if (en[k]) begin
        for (int i = 0; i < rbs_pkg::LANES; i++) begin
          lp_q[k][i] <= rbs_pkg::div_step(lp_q[k-1][i]);
        end
        meta_q[k] <= meta_q[k-1];
      end
    end
    if (en[NS-1]) begin
      meta_q[NS-1] <= meta_q[NS-2];
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [rbs_pkg::T_W-1:0] ta, tb;
    if (en[NS-1]) begin
      for (int i = 0; i < rbs_pkg::AXES; i++) begin
        ta = rbs_pkg::lane_result(lp_q[rbs_pkg::DIV_STAGES][2*i]);
        tb = rbs_pkg::lane_result(lp_q[rbs_pkg::DIV_STAGES][2*i+1]);
        mlo_q[i] <= (ta < tb) ? ta : tb;
        mhi_q[i] <= (ta < tb) ? tb : ta;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [rbs_pkg::T_W-1:0] nr, fr;
    if (en[NS]) begin
      nr = meta_q[NS-1].lo;
      fr = meta_q[NS-1].hi;
      for (int i = 0; i < rbs_pkg::AXES; i++) begin
        if (mlo_q[i] > nr) nr = mlo_q[i];
        if (mhi_q[i] < fr) fr = mhi_q[i];
      end
      if (!meta_q[NS-1].is_test) begin
        st_q   <= rbs_pkg::ST_LOADED;
        near_q <= '0;
        far_q  <= '0;
      end else if (nr < fr) begin
        if (nr > meta_q[NS-1].lo) begin
          st_q   <= rbs_pkg::ST_ENTER;
          near_q <= nr;
        end else begin
          st_q   <= rbs_pkg::ST_INSIDE;
          near_q <= '0;
        end
        far_q <= fr;
      end else begin
        st_q   <= rbs_pkg::ST_MISS;
        near_q <= '0;
        far_q  <= '0;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign status_o    = st_q;
  assign t_near_o    = near_q;
  assign t_far_o     = far_q;

endmodule
`default_nettype wire

// ----- sv/ray_box_slab_intersect.sv -----
`default_nettype none
// Ray versus axis-aligned box slab test in signed Q16.16. A load item stores the
// ray; a test item checks one box against the stored ray and yields one result
// item per input item, in order. One item per cycle is accepted while in_stall_o is
// low. An accepted item passes through the two-entry queue, a stage that sets up
// the divide, 11 divider stages (3 quotient bits per stage, six lanes), a stage for
// the per-axis min and max, and a stage that combines and registers the result.
module ray_box_slab_intersect (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              req_type_i,
  input  wire logic signed [rbs_pkg::T_W-1:0]    vec_a_x_i,
  input  wire logic signed [rbs_pkg::T_W-1:0]    vec_a_y_i,
  input  wire logic signed [rbs_pkg::T_W-1:0]    vec_a_z_i,
  input  wire logic signed [rbs_pkg::T_W-1:0]    vec_b_x_i,
  input  wire logic signed [rbs_pkg::T_W-1:0]    vec_b_y_i,
  input  wire logic signed [rbs_pkg::T_W-1:0]    vec_b_z_i,
  input  wire logic signed [rbs_pkg::T_W-1:0]    interval_lo_i,
  input  wire logic signed [rbs_pkg::T_W-1:0]    interval_hi_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [1:0]                             status_o,
  output logic signed [rbs_pkg::T_W-1:0]         t_near_o,
  output logic signed [rbs_pkg::T_W-1:0]         t_far_o
);

  logic [rbs_pkg::AXES-1:0][rbs_pkg::T_W-1:0] vec_a, vec_b;
  logic           push_valid, push_full, pop_valid, pop_stall;
  rbs_pkg::item_t push_item, pop_item;

  assign vec_a = {vec_a_z_i, vec_a_y_i, vec_a_x_i};
  assign vec_b = {vec_b_z_i, vec_b_y_i, vec_b_x_i};

  rbs_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .req_type_i,
    .vec_a_i(vec_a), .vec_b_i(vec_b), .interval_lo_i, .interval_hi_i,
    .push_valid_o(push_valid), .push_full_i(push_full), .push_item_o(push_item)
  );

  rbs_queue u_queue (
    .clk_i, .rst_ni,
    .push_valid_i(push_valid), .push_full_o(push_full), .push_item_i(push_item),
    .pop_valid_o(pop_valid), .pop_stall_i(pop_stall), .pop_item_o(pop_item)
  );

  rbs_back u_back (
    .clk_i, .rst_ni,
    .pop_valid_i(pop_valid), .pop_stall_o(pop_stall), .pop_item_i(pop_item),
    .out_valid_o, .out_stall_i, .status_o, .t_near_o, .t_far_o
  );

`ifndef SYNTHESIS
  a_load_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == rbs_pkg::ST_LOADED |-> t_near_o == '0 && t_far_o == '0)
    else $error("load result carries nonzero t");
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == rbs_pkg::ST_MISS |-> t_near_o == '0 && t_far_o == '0)
    else $error("miss result carries nonzero t");
  a_enter_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == rbs_pkg::ST_ENTER |-> t_near_o < t_far_o)
    else $error("entering hit with near not before far");
  a_inside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == rbs_pkg::ST_INSIDE |-> t_near_o == '0)
    else $error("inside hit with nonzero near");
`endif

endmodule
`default_nettype wire
